// ----- hdl/btpc_pkg.sv -----
// Package for the barometer compensation block: widths, register indexes,
// sequencer states, datapath step codes and the command/status structs.
// No dependencies.
package btpc_pkg;

   localparam int RAW_W   = 24;
   localparam int COEFF_W = 16;
   localparam int NUM_COEFF = 6;
   localparam int IDX_W   = 3;
   localparam int DT_W    = 25;
   localparam int TEMP_W  = 20;
   localparam int TOUT_W  = 19;
   localparam int PRES_W  = 25;
   localparam int OPND_W  = 26;
   localparam int PROD_W  = 2 * OPND_W;
   localparam int WIDE_W  = 40;
   localparam int ACC_W   = 64;
   localparam int DIFF_W  = 44;

   // configuration register indexes
   localparam logic [IDX_W-1:0] REG_SENS_BASE     = 3'd0;
   localparam logic [IDX_W-1:0] REG_OFFSET_BASE   = 3'd1;
   localparam logic [IDX_W-1:0] REG_SENS_TEMPCO   = 3'd2;
   localparam logic [IDX_W-1:0] REG_OFFSET_TEMPCO = 3'd3;
   localparam logic [IDX_W-1:0] REG_REF_TEMP      = 3'd4;
   localparam logic [IDX_W-1:0] REG_TEMP_SENS     = 3'd5;

   localparam int TEMP_REF  = 2000;
   localparam int TEMP_LOW  = -1500;
   localparam int TOUT_MAX  = 140000;
   localparam int TOUT_MIN  = -140000;

   typedef enum logic [3:0] {
      ST_IDLE, ST_TMUL, ST_TEMP, ST_T2, ST_OFF, ST_SENS, ST_SQ1, ST_SQ2,
      ST_ADJ, ST_PLO, ST_PHI, ST_PACC, ST_PDIV, ST_PRES, ST_DONE
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE, OP_TMUL, OP_TEMP, OP_T2, OP_OFF, OP_SENS, OP_SQ1, OP_SQ2,
      OP_ADJ, OP_PLO, OP_PHI, OP_PACC, OP_PDIV, OP_PRES
   } op_type;

   typedef struct packed {
      logic   accept;
      logic   emit;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic is_pressure;
   } status_type;

endpackage

// ----- hdl/btpc_dpath.sv -----
// Datapath: coefficient registers, stored dT, one shared signed multiplier
// with registered product, and the compensation registers.
// Depends on btpc_pkg.
module btpc_dpath (
   input  logic                             clock,
   input  logic                             reset,
   input  btpc_pkg::cmd_type                cmd,
   output btpc_pkg::status_type             status,
   input  logic                             csr_we,
   input  logic [btpc_pkg::IDX_W-1:0]       csr_index,
   input  logic [btpc_pkg::COEFF_W-1:0]     csr_wdata,
   input  logic                             req_func,
   input  logic [btpc_pkg::RAW_W-1:0]       req_raw_value,
   output logic                             rsp_kind,
   output logic signed [btpc_pkg::TOUT_W-1:0] rsp_temperature_centi,
   output logic signed [btpc_pkg::PRES_W-1:0] rsp_pressure_pa,
   output logic                             rsp_no_temperature_yet
);
   import btpc_pkg::*;

   // signed divide by 2^k, truncating toward zero
   function automatic logic signed [ACC_W-1:0] trunc_shr(
      input logic signed [ACC_W-1:0] v, input int k);
      logic signed [ACC_W-1:0] bias;
      bias = v[ACC_W-1] ? ((ACC_W'(1) <<< k) - ACC_W'(1)) : '0;
      return (v + bias) >>> k;
   endfunction

   logic [COEFF_W-1:0]        coeff_ff [NUM_COEFF];
   logic signed [DT_W-1:0]    dt_ff;
   logic                      seen_ff;
   logic                      func_ff;
   logic [RAW_W-1:0]          raw_ff;
   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [TEMP_W-1:0]  temp_ff;
   logic signed [TOUT_W-1:0]  tout_ff;
   logic signed [WIDE_W-1:0]  off_ff, sens_ff, off2_ff, sens2_ff;
   logic signed [ACC_W-1:0]   acc_ff;
   logic signed [DIFF_W-1:0]  diff_ff;
   logic signed [PRES_W-1:0]  pres_ff;
   logic                      kind_ff, nty_ff;
   logic signed [TOUT_W-1:0]  tcent_ff;
   logic signed [PRES_W-1:0]  pout_ff;

   logic signed [OPND_W-1:0]  opa, opb;
   logic signed [PROD_W-1:0]  prod_in;
   logic signed [ACC_W-1:0]   prod64;
   logic signed [ACC_W-1:0]   t2_full, tout_full, pq_full;
   logic signed [DT_W-1:0]    dt_in;
   logic                      cold, very_cold;

   assign status.is_pressure = func_ff;
   assign prod64    = ACC_W'(prod_ff);
   assign cold      = temp_ff < TEMP_W'(TEMP_REF);
   assign very_cold = temp_ff < TEMP_W'(TEMP_LOW);
   assign dt_in     = signed'({1'b0, req_raw_value})
                    - signed'({1'b0, coeff_ff[REG_REF_TEMP], 8'b0});

   // configuration writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_COEFF; i++) coeff_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            REG_SENS_BASE:     coeff_ff[0] <= csr_wdata;
            REG_OFFSET_BASE:   coeff_ff[1] <= csr_wdata;
            REG_SENS_TEMPCO:   coeff_ff[2] <= csr_wdata;
            REG_OFFSET_TEMPCO: coeff_ff[3] <= csr_wdata;
            REG_REF_TEMP:      coeff_ff[4] <= csr_wdata;
            REG_TEMP_SENS:     coeff_ff[5] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stored dT and the temperature-seen flag
   always_ff @(posedge clock) begin
      if (reset) begin
         dt_ff   <= '0;
         seen_ff <= 1'b0;
      end else if (cmd.accept && !req_func) begin
         dt_ff   <= dt_in;
         seen_ff <= 1'b1;
      end
   end

   // shared multiplier operand select
   always_comb begin
      unique case (cmd.op)
         OP_TMUL: begin opa = OPND_W'(dt_ff); opb = OPND_W'(coeff_ff[REG_TEMP_SENS]); end
         OP_TEMP: begin opa = OPND_W'(dt_ff); opb = OPND_W'(dt_ff); end
         OP_T2:   begin opa = OPND_W'(dt_ff); opb = OPND_W'(coeff_ff[REG_OFFSET_TEMPCO]); end
         OP_OFF:  begin opa = OPND_W'(dt_ff); opb = OPND_W'(coeff_ff[REG_SENS_TEMPCO]); end
         OP_SENS: begin
            opa = OPND_W'(temp_ff) - OPND_W'(TEMP_REF);
            opb = OPND_W'(temp_ff) - OPND_W'(TEMP_REF);
         end
         OP_SQ1: begin
            opa = OPND_W'(temp_ff) - OPND_W'(TEMP_LOW);
            opb = OPND_W'(temp_ff) - OPND_W'(TEMP_LOW);
         end
         OP_PLO: begin
            opa = OPND_W'(raw_ff);
            opb = OPND_W'(sens_ff[19:0]);
         end
         OP_PHI: begin
            opa = OPND_W'(raw_ff);
            opb = OPND_W'(signed'(sens_ff[WIDE_W-1:20]));
         end
         default: begin opa = '0; opb = '0; end
      endcase
   end

   assign prod_in   = opa * opb;
   assign t2_full   = trunc_shr(prod64, 31);
   assign tout_full = ACC_W'(temp_ff) - (cold ? t2_full : '0);
   assign pq_full   = trunc_shr(ACC_W'(diff_ff), 15);

   // compensation steps, one per sequencer state
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.accept) begin
         func_ff <= req_func;
         raw_ff  <= req_raw_value;
      end
      unique case (cmd.op)
         OP_TEMP: temp_ff <= TEMP_W'(ACC_W'(TEMP_REF) + trunc_shr(prod64, 23));
         OP_T2: begin
            if (tout_full > ACC_W'(TOUT_MAX))      tout_ff <= TOUT_W'(TOUT_MAX);
            else if (tout_full < ACC_W'(TOUT_MIN)) tout_ff <= TOUT_W'(TOUT_MIN);
            else                                   tout_ff <= TOUT_W'(tout_full);
         end
         OP_OFF: off_ff <= WIDE_W'({coeff_ff[REG_OFFSET_BASE], 16'b0})
                         + WIDE_W'(trunc_shr(prod64, 7));
         OP_SENS: sens_ff <= WIDE_W'({coeff_ff[REG_SENS_BASE], 15'b0})
                           + WIDE_W'(trunc_shr(prod64, 8));
         OP_SQ1: begin
            // product is a square, never negative: plain shifts truncate
            off2_ff  <= cold ? WIDE_W'((prod64 * 5) >>> 1) : '0;
            sens2_ff <= cold ? WIDE_W'((prod64 * 5) >>> 2) : '0;
         end
         OP_SQ2: if (very_cold) begin
            off2_ff  <= off2_ff + WIDE_W'(prod64 * 7);
            sens2_ff <= sens2_ff + WIDE_W'((prod64 * 11) >>> 1);
         end
         OP_ADJ: begin
            off_ff  <= off_ff - off2_ff;
            sens_ff <= sens_ff - sens2_ff;
         end
         OP_PHI:  acc_ff <= prod64;
         OP_PACC: acc_ff <= acc_ff + (prod64 <<< 20);
         OP_PDIV: diff_ff <= DIFF_W'(trunc_shr(acc_ff, 21)) - DIFF_W'(off_ff);
         OP_PRES: begin
            if (pq_full > ACC_W'(16777215))       pres_ff <= PRES_W'(16777215);
            else if (pq_full < -ACC_W'(16777216)) pres_ff <= PRES_W'(-16777216);
            else                                  pres_ff <= PRES_W'(pq_full);
         end
         default: ;
      endcase
   end

   // result register
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         kind_ff  <= func_ff;
         tcent_ff <= tout_ff;
         pout_ff  <= func_ff ? pres_ff : '0;
         nty_ff   <= !seen_ff;
      end
   end

   assign rsp_kind               = kind_ff;
   assign rsp_temperature_centi  = tcent_ff;
   assign rsp_pressure_pa        = pout_ff;
   assign rsp_no_temperature_yet = nty_ff;

endmodule

// ----- hdl/btpc_ctrl.sv -----
// Sequencer: walks one transaction through the datapath steps and owns the
// handshakes. Depends on btpc_pkg.
module btpc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  btpc_pkg::status_type status,
   output btpc_pkg::cmd_type    cmd
);
   import btpc_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // next state
   always_comb begin
      unique case (state_ff)
         ST_IDLE: state_in = req_valid ? ST_TMUL : ST_IDLE;
         ST_TMUL: state_in = ST_TEMP;
         ST_TEMP: state_in = ST_T2;
         ST_T2:   state_in = status.is_pressure ? ST_OFF : ST_DONE;
         ST_OFF:  state_in = ST_SENS;
         ST_SENS: state_in = ST_SQ1;
         ST_SQ1:  state_in = ST_SQ2;
         ST_SQ2:  state_in = ST_ADJ;
         ST_ADJ:  state_in = ST_PLO;
         ST_PLO:  state_in = ST_PHI;
         ST_PHI:  state_in = ST_PACC;
         ST_PACC: state_in = ST_PDIV;
         ST_PDIV: state_in = ST_PRES;
         ST_PRES: state_in = ST_DONE;
         ST_DONE: state_in = out_free ? ST_IDLE : ST_DONE;
         default: state_in = ST_IDLE;
      endcase
   end

   // commands
   always_comb begin
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.emit   = (state_ff == ST_DONE) && out_free;
      unique case (state_ff)
         ST_TMUL: cmd.op = OP_TMUL;
         ST_TEMP: cmd.op = OP_TEMP;
         ST_T2:   cmd.op = OP_T2;
         ST_OFF:  cmd.op = OP_OFF;
         ST_SENS: cmd.op = OP_SENS;
         ST_SQ1:  cmd.op = OP_SQ1;
         ST_SQ2:  cmd.op = OP_SQ2;
         ST_ADJ:  cmd.op = OP_ADJ;
         ST_PLO:  cmd.op = OP_PLO;
         ST_PHI:  cmd.op = OP_PHI;
         ST_PACC: cmd.op = OP_PACC;
         ST_PDIV: cmd.op = OP_PDIV;
         ST_PRES: cmd.op = OP_PRES;
         default: cmd.op = OP_NONE;
      endcase
   end

   // output valid
   always_comb begin
      if (cmd.emit)                  rsp_valid_in = 1'b1;
      else if (rsp_ready)            rsp_valid_in = 1'b0;
      else                           rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef ASSERT_OFF
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transaction");
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ST_TMUL))
      else $error("accepted transaction did not start");
   a_temp_short: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_T2 && !status.is_pressure) |=> (state_ff == ST_DONE))
      else $error("temperature transaction ran pressure steps");
   a_emit_shown: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("emitted result not presented");
`endif

endmodule

// ----- hdl/barometer_temp_pressure_compensation.sv -----
// Top level of the barometer temperature/pressure compensation block.
// Joins btpc_ctrl and btpc_dpath; depends on btpc_pkg.
//
//  channel | ports                                  | flow
//  req     | req_valid/ready, func, raw_value       | in
//  rsp     | rsp_valid/ready, kind, temp, pres, nty | out
//  csr     | csr_we, csr_index, csr_wdata           | in, write only
//
// A temperature transaction runs the TMUL, TEMP and T2 steps; a pressure transaction
// goes on through OFF to PRES. A new request is accepted only back in idle.
// All products go through one shared 26x26 multiplier, one per cycle.
// Reset is synchronous and clears coefficients, stored dT and the sequencer.
// A finished result waits in the output register; a stalled result holds
// the sequencer in its last step until the output frees.
module barometer_temp_pressure_compensation (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [btpc_pkg::IDX_W-1:0]         csr_index,
   input  logic [btpc_pkg::COEFF_W-1:0]       csr_wdata,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_func,
   input  logic [btpc_pkg::RAW_W-1:0]         req_raw_value,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_kind,
   output logic signed [btpc_pkg::TOUT_W-1:0] rsp_temperature_centi,
   output logic signed [btpc_pkg::PRES_W-1:0] rsp_pressure_pa,
   output logic                               rsp_no_temperature_yet
);
   import btpc_pkg::*;

   cmd_type    cmd;
   status_type status;

   btpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   btpc_dpath u_dpath (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .status                 (status),
      .csr_we                 (csr_we),
      .csr_index              (csr_index),
      .csr_wdata              (csr_wdata),
      .req_func               (req_func),
      .req_raw_value          (req_raw_value),
      .rsp_kind               (rsp_kind),
      .rsp_temperature_centi  (rsp_temperature_centi),
      .rsp_pressure_pa        (rsp_pressure_pa),
      .rsp_no_temperature_yet (rsp_no_temperature_yet)
   );

endmodule
